### hw/rtl/hrbh_pkg.sv
// shared types, codes and character helpers for the hex record bit histogram
package hrbh_pkg;

	localparam int W_MODE = 1;
	localparam int W_CHAR = 8;
	localparam int W_BIT_INDEX = 6;
	localparam int W_OUT = 48;
	localparam int W_REC = 4;
	localparam logic [W_REC-1:0] REC_BYTES_RESET = 4'd8;

	localparam logic [W_CHAR-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [W_CHAR-1:0] CH_TAB = 8'h09;
	localparam logic [W_CHAR-1:0] CH_VTAB = 8'h0B;
	localparam logic [W_CHAR-1:0] CH_FFEED = 8'h0C;
	localparam logic [W_CHAR-1:0] CH_CRET = 8'h0D;
	localparam logic [W_CHAR-1:0] CH_SPACE = 8'h20;
	localparam logic [W_CHAR-1:0] CH_0 = 8'h30;
	localparam logic [W_CHAR-1:0] CH_9 = 8'h39;
	localparam logic [W_CHAR-1:0] CH_UA = 8'h41;
	localparam logic [W_CHAR-1:0] CH_UF = 8'h46;
	localparam logic [W_CHAR-1:0] CH_LA = 8'h61;
	localparam logic [W_CHAR-1:0] CH_LF = 8'h66;
	localparam logic [4:0] HEX_NONE = 5'd16;

	typedef enum logic [1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_READ   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NIB_WAIT,
		ST_BIT,
		ST_CNT_WAIT,
		ST_RD_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic line_end;
		logic ok;
		logic commit;
		logic rd;
	} seq_req_t;

	typedef struct packed {
		logic  idle;
		logic  emit;
		kind_t kind;
	} seq_stat_t;

	function automatic logic [4:0] hex_value(input logic [W_CHAR-1:0] c);
		logic [4:0] v;
		v = HEX_NONE;
		if (c inside {[CH_0:CH_9]}) begin
			v = 5'(c - CH_0);
		end else if (c inside {[CH_UA:CH_UF]}) begin
			v = 5'(c - CH_UA) + 5'd10;
		end else if (c inside {[CH_LA:CH_LF]}) begin
			v = 5'(c - CH_LA) + 5'd10;
		end
		return v;
	endfunction

	function automatic logic is_blank(input logic [W_CHAR-1:0] c);
		return c inside {CH_SPACE, CH_TAB, CH_VTAB, CH_FFEED, CH_CRET};
	endfunction

endpackage

### hw/rtl/hrbh_if.sv
// request and result channel interfaces
interface hrbh_in_if;
	import hrbh_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [W_MODE-1:0]      mode;
	logic [W_CHAR-1:0]      char_byte;
	logic [W_BIT_INDEX-1:0] bit_index;
	modport source (output valid, mode, char_byte, bit_index, input ready);
	modport sink (input valid, mode, char_byte, bit_index, output ready);
endinterface

interface hrbh_out_if;
	import hrbh_pkg::*;
	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic [W_OUT-1:0] bit_count;
	logic [W_OUT-1:0] line_total;
	modport source (output valid, kind, bit_count, line_total, input ready);
	modport sink (input valid, kind, bit_count, line_total, output ready);
endinterface

### hw/rtl/hrbh_ram.sv
// generic single write port ram with registered read
module hrbh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### hw/rtl/hrbh_seq.sv
// line commit and counter read sequencer around the shared counter incrementer
module hrbh_seq #(
	parameter int MAX_BYTES = 8,
	parameter int COUNT_WIDTH = 48
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  hrbh_pkg::seq_req_t                        req,
	input  logic [hrbh_pkg::W_BIT_INDEX-1:0]          bit_index,
	input  logic [$clog2(8*MAX_BYTES)-1:0]            pad,
	input  logic [$clog2(2*MAX_BYTES+2)-1:0]          dc,
	output logic                                      nib_re,
	output logic [$clog2(2*MAX_BYTES)-1:0]            nib_raddr,
	input  logic [3:0]                                nib_rdata,
	input  logic                                      out_free,
	output hrbh_pkg::seq_stat_t                       stat,
	output logic [COUNT_WIDTH-1:0]                    count
);
	import hrbh_pkg::*;

	localparam int POS_DEPTH = 8 * MAX_BYTES;
	localparam int PW = $clog2(POS_DEPTH);
	localparam int NAW = $clog2(2 * MAX_BYTES);
	localparam int DCW = $clog2(2 * MAX_BYTES + 2);
	localparam int IXW = (PW > W_BIT_INDEX) ? PW : W_BIT_INDEX;

	state_t                 state_q, state_d;
	kind_t                  kind_q;
	logic [PW-1:0]          pos_q;
	logic [DCW-1:0]         dc_q;
	logic [DCW-1:0]         nib_idx_q;
	logic [DCW-1:0]         nxt_idx;
	logic [1:0]             k_q;
	logic [3:0]             nib_q;
	logic                   range_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [POS_DEPTH-1:0]   valid_q;

	logic                   cur_bit;
	logic                   step;
	logic                   last;
	logic                   in_range;
	logic [IXW-1:0]         idx_ext;
	logic [PW-1:0]          rd_addr;
	logic                   cnt_re;
	logic                   cnt_we;
	logic [PW-1:0]          cnt_raddr;
	logic [COUNT_WIDTH-1:0] cnt_rdata;
	logic [COUNT_WIDTH-1:0] cur;
	logic [COUNT_WIDTH-1:0] inc;

	assign idx_ext  = IXW'(bit_index);
	assign rd_addr  = idx_ext[PW-1:0];
	assign in_range = 32'(bit_index) < POS_DEPTH;
	assign cur_bit  = nib_q[~k_q];
	assign nxt_idx  = nib_idx_q + DCW'(1);
	assign last     = (k_q == 2'd3) && (nxt_idx == dc_q);
	assign step     = ((state_q == ST_BIT) && !cur_bit) || (state_q == ST_CNT_WAIT);

	// shared saturating incrementer
	assign cur = valid_q[pos_q] ? cnt_rdata : '0;
	assign inc = (&cur) ? cur : cur + COUNT_WIDTH'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.rd) begin
					state_d = ST_RD_WAIT;
				end else if (req.line_end) begin
					state_d = req.commit ? ST_NIB_WAIT : ST_EMIT;
				end
			end
			ST_NIB_WAIT: state_d = ST_BIT;
			ST_BIT, ST_CNT_WAIT: begin
				if ((state_q == ST_BIT) && cur_bit) begin
					state_d = ST_CNT_WAIT;
				end else if (last) begin
					state_d = ST_EMIT;
				end else if (k_q == 2'd3) begin
					state_d = ST_NIB_WAIT;
				end else begin
					state_d = ST_BIT;
				end
			end
			ST_RD_WAIT: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		nib_re    = 1'b0;
		nib_raddr = nxt_idx[NAW-1:0];
		cnt_re    = 1'b0;
		cnt_raddr = pos_q;
		cnt_we    = 1'b0;
		stat.idle = 1'b0;
		stat.emit = 1'b0;
		stat.kind = kind_q;
		case (state_q)
			ST_IDLE: begin
				stat.idle = 1'b1;
				nib_re    = req.line_end && req.commit;
				nib_raddr = '0;
				cnt_re    = req.rd && in_range;
				cnt_raddr = rd_addr;
			end
			ST_BIT: begin
				cnt_re = cur_bit;
				nib_re = !cur_bit && (k_q == 2'd3) && !last;
			end
			ST_CNT_WAIT: begin
				cnt_we = 1'b1;
				nib_re = (k_q == 2'd3) && !last;
			end
			ST_EMIT: stat.emit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (cnt_we) begin
				valid_q[pos_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			if (req.rd) begin
				kind_q  <= KIND_READ;
				pos_q   <= rd_addr;
				range_q <= in_range;
			end else if (req.line_end) begin
				kind_q    <= req.ok ? KIND_ACCEPT : KIND_REJECT;
				pos_q     <= pad;
				dc_q      <= dc;
				nib_idx_q <= '0;
				cnt_q     <= '0;
			end
		end
		if (state_q == ST_NIB_WAIT) begin
			nib_q <= nib_rdata;
			k_q   <= 2'd0;
		end
		if (step) begin
			pos_q <= pos_q + PW'(1);
			k_q   <= k_q + 2'd1;
			if (k_q == 2'd3) begin
				nib_idx_q <= nxt_idx;
			end
		end
		if (state_q == ST_RD_WAIT) begin
			cnt_q <= range_q ? cur : '0;
		end
	end

	assign count = cnt_q;

	hrbh_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(POS_DEPTH)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(pos_q),
		.wdata(inc),
		.re   (cnt_re),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	a_write_only_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> kind_q == KIND_ACCEPT)
		else $error("counter update outside an accepted line");

	a_counted_bit_set: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CNT_WAIT |-> nib_q[~k_q])
		else $error("counter update for a clear bit");

	a_nibble_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BIT |-> nib_idx_q < dc_q)
		else $error("commit ran past the digits of the line");

	a_far_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && kind_q == KIND_READ && !range_q) |-> cnt_q == '0)
		else $error("read beyond the counters returned data");
endmodule

### hw/rtl/hex_record_bit_histogram.sv
// top level of the hex record bit-position histogram
//
// stream (sink): handshake, one request per cycle while ready. mode 0 carries a record
// character; mode 1 reads the counter at bit_index together with the line total.
// result (source): one result per newline (accepted or rejected line) and one per
// read; characters other than newline give no result.
// cfg_we / cfg_wdata set the record width in bytes; the user must write it only
// while idle, which the block does not enforce. a character other than newline
// leaves the block idle. a newline walks every bit of the line's digits and
// updates the counters through the single shared incrementer, one set bit at a
// time; an empty or rejected line and a read skip the walk.
// stream.ready is low from a newline or read request until its result is loaded.
// the result sits in an output register; while the receiver stalls, characters
// are still taken, and the next newline or read waits for that register.
// reset clears the counters (per-entry valid bits), the line total and the line
// state, and sets the record width to 8 bytes; no clearing pass is needed.
module hex_record_bit_histogram #(
	parameter int MAX_BYTES = 8,
	parameter int COUNT_WIDTH = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	hrbh_in_if.sink                     stream,
	hrbh_out_if.source                  result,
	input  logic                        cfg_we,
	input  logic [hrbh_pkg::W_REC-1:0]  cfg_wdata
);
	import hrbh_pkg::*;

	localparam int NIB_DEPTH = 2 * MAX_BYTES;
	localparam int POS_DEPTH = 8 * MAX_BYTES;
	localparam int PW = $clog2(POS_DEPTH);
	localparam int NAW = $clog2(NIB_DEPTH);
	localparam int DCW = $clog2(2 * MAX_BYTES + 2);
	localparam int WW = $clog2(MAX_BYTES + 1);

	logic [W_REC-1:0]       cfg_q;
	logic [DCW-1:0]         dc_q;
	logic                   inv_q;
	logic [COUNT_WIDTH-1:0] lines_q;
	logic                   out_valid_q;
	kind_t                  out_kind_q;
	logic [W_OUT-1:0]       out_count_q;
	logic [W_OUT-1:0]       out_total_q;

	logic                   acc;
	logic                   is_nl;
	logic [4:0]             hv;
	logic [WW-1:0]          width;
	logic [9:0]             dc_ext;
	logic [9:0]             pad_full;
	logic                   ok;
	logic                   out_free;
	logic                   nib_we;
	logic                   nib_re;
	logic [NAW-1:0]         nib_raddr;
	logic [3:0]             nib_rdata;
	logic [COUNT_WIDTH-1:0] count;
	seq_req_t               req;
	seq_stat_t              stat;

	assign stream.ready = stat.idle;
	assign acc   = stream.valid && stream.ready;
	assign is_nl = (stream.char_byte == CH_NEWLINE);
	assign hv    = hex_value(stream.char_byte);

	always_comb begin
		if (cfg_q == '0) begin
			width = WW'(1);
		end else if (32'(cfg_q) > MAX_BYTES) begin
			width = WW'(MAX_BYTES);
		end else begin
			width = WW'(cfg_q);
		end
	end

	assign dc_ext   = 10'(dc_q);
	assign ok       = !inv_q && !dc_q[0] && (dc_ext <= (10'(width) << 1));
	assign pad_full = (10'(width) - (dc_ext >> 1)) << 3;

	assign req.line_end = acc && !stream.mode[0] && is_nl;
	assign req.ok       = ok;
	assign req.commit   = ok && (dc_q != '0);
	assign req.rd       = acc && stream.mode[0];

	assign nib_we   = acc && !stream.mode[0] && !is_nl && !is_blank(stream.char_byte) &&
		(hv != HEX_NONE) && (32'(dc_q) < NIB_DEPTH);
	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= REC_BYTES_RESET;
			dc_q        <= '0;
			inv_q       <= 1'b0;
			lines_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (acc && !stream.mode[0]) begin
				if (is_nl) begin
					dc_q    <= '0;
					inv_q   <= 1'b0;
					lines_q <= (&lines_q) ? lines_q : lines_q + COUNT_WIDTH'(1);
				end else if (!is_blank(stream.char_byte)) begin
					if (hv == HEX_NONE) begin
						inv_q <= 1'b1;
					end else if (32'(dc_q) <= NIB_DEPTH) begin
						dc_q <= dc_q + DCW'(1);
					end
				end
			end
			if (stat.emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stat.emit) begin
			out_kind_q  <= stat.kind;
			out_count_q <= (stat.kind == KIND_READ) ? W_OUT'(count) : '0;
			out_total_q <= W_OUT'(lines_q);
		end
	end

	assign result.valid      = out_valid_q;
	assign result.kind       = out_kind_q;
	assign result.bit_count  = out_count_q;
	assign result.line_total = out_total_q;

	hrbh_ram #(
		.WIDTH(4),
		.DEPTH(NIB_DEPTH)
	) u_nib_ram (
		.clk  (clk),
		.we   (nib_we),
		.waddr(dc_q[NAW-1:0]),
		.wdata(hv[3:0]),
		.re   (nib_re),
		.raddr(nib_raddr),
		.rdata(nib_rdata)
	);

	hrbh_seq #(
		.MAX_BYTES  (MAX_BYTES),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.bit_index(stream.bit_index),
		.pad      (PW'(pad_full)),
		.dc       (dc_q),
		.nib_re   (nib_re),
		.nib_raddr(nib_raddr),
		.nib_rdata(nib_rdata),
		.out_free (out_free),
		.stat     (stat),
		.count    (count)
	);
endmodule

### tb/sv/hrbh_tb_pkg.sv
// scoreboard with a bit-position histogram predictor for the hex record histogram
`timescale 1ns / 100ps
package hrbh_tb_pkg;
	import hrbh_pkg::*;

	localparam int NIBBLE_SLOTS = 16;
	localparam int BIT_SLOTS = 64;
	localparam int WIDTH_CAP = 8;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		kind_t            kind;
		logic [W_OUT-1:0] bit_count;
		logic [W_OUT-1:0] line_total;
	} outcome_t;

	class histogram_scoreboard;
		bit [3:0]       nibbles [NIBBLE_SLOTS];
		int unsigned    digits;
		bit             bad_line;
		bit [W_OUT-1:0] tallies [BIT_SLOTS];
		bit [W_OUT-1:0] lines;
		bit [W_REC-1:0] record_bytes;
		outcome_t       awaited [$];
		int unsigned    mismatches;

		function new();
			foreach (nibbles[i]) nibbles[i] = '0;
			foreach (tallies[i]) tallies[i] = '0;
			digits = 0;
			bad_line = 1'b0;
			lines = '0;
			record_bytes = REC_BYTES_RESET;
			mismatches = 0;
		endfunction

		function void set_width(bit [W_REC-1:0] v);
			record_bytes = v;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function bit [W_OUT-1:0] bump(bit [W_OUT-1:0] v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		function int unsigned nibble_of(bit [W_CHAR-1:0] c);
			if (c >= CH_0 && c <= CH_9) return c - CH_0;
			if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
			if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
			return 16;
		endfunction

		function bit blank(bit [W_CHAR-1:0] c);
			return c == CH_SPACE || c == CH_TAB || c == CH_VTAB || c == CH_FFEED || c == CH_CRET;
		endfunction

		function outcome_t close_line();
			outcome_t o;
			int unsigned w;
			int unsigned pad;
			int unsigned pos;
			bit ok;
			w = (record_bytes == 0) ? 1 : ((record_bytes > WIDTH_CAP) ? WIDTH_CAP : record_bytes);
			ok = !bad_line && (digits % 2 == 0) && (digits <= 2 * w);
			lines = bump(lines);
			if (ok) begin
				pad = (w - digits / 2) * 8;
				for (int i = 0; i < digits; i++) begin
					for (int k = 0; k < 4; k++) begin
						pos = pad + i * 4 + k;
						if (pos < BIT_SLOTS && nibbles[i][3-k])
							tallies[pos] = bump(tallies[pos]);
					end
				end
			end
			o.kind = ok ? KIND_ACCEPT : KIND_REJECT;
			o.bit_count = '0;
			o.line_total = lines;
			digits = 0;
			bad_line = 1'b0;
			return o;
		endfunction

		function void take_request(bit m, bit [W_CHAR-1:0] c, bit [W_BIT_INDEX-1:0] idx);
			outcome_t o;
			int unsigned nib;
			if (m) begin
				o.kind = KIND_READ;
				o.bit_count = tallies[idx];
				o.line_total = lines;
				awaited.push_back(o);
			end else if (c == CH_NEWLINE) begin
				awaited.push_back(close_line());
			end else if (!blank(c)) begin
				nib = nibble_of(c);
				if (nib > 15) begin
					bad_line = 1'b1;
				end else begin
					if (digits < NIBBLE_SLOTS) nibbles[digits] = nib[3:0];
					if (digits <= NIBBLE_SLOTS) digits++;
				end
			end
		endfunction

		function void match_result(logic [1:0] kind, logic [W_OUT-1:0] cnt,
				logic [W_OUT-1:0] total);
			outcome_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: kind %0d count %0d total %0d",
						kind, cnt, total);
				return;
			end
			want = awaited.pop_front();
			if (kind !== want.kind || cnt !== want.bit_count || total !== want.line_total) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("mismatch: expected kind %0d count %0d total %0d, got kind %0d count %0d total %0d",
						want.kind, want.bit_count, want.line_total, kind, cnt, total);
			end
		endfunction
	endclass

endpackage

### tb/sv/tb.sv
// testbench top: clock, reset, request driver, result checker and watchdog
`timescale 1ns / 100ps
module tb;
	import hrbh_pkg::*;
	import hrbh_tb_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 200;
	localparam int LONG_HOLD = 400;
	localparam int RANDOM_ITEMS = 1500;
	localparam int PHASES = 7;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [W_REC-1:0] cfg_wdata;

	hrbh_in_if  stream_if ();
	hrbh_out_if result_if ();

	histogram_scoreboard tracker;
	bit                  calm;
	bit                  hold_pending;
	bit                  sender_jitter;
	int unsigned         sent_items;
	bit [W_REC-1:0]      width_now;

	hex_record_bit_histogram u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic offer(input bit m, input bit [W_CHAR-1:0] c, input bit [W_BIT_INDEX-1:0] idx);
		int unsigned gap;
		if (!calm && $urandom_range(0, 29) == 0) sender_jitter = !sender_jitter;
		if (!calm && sender_jitter && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 15);
			stream_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream_if.valid <= 1'b1;
		stream_if.mode <= m;
		stream_if.char_byte <= c;
		stream_if.bit_index <= idx;
		do @(negedge clk); while (stream_if.ready !== 1'b1);
		@(posedge clk);
		tracker.take_request(m, c, idx);
		if (m || !tracker.blank(c)) sent_items++;
	endtask

	task automatic settle();
		stream_if.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(input bit [W_REC-1:0] w);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_width(w);
		width_now = w;
	endtask

	function automatic bit [W_CHAR-1:0] digit_char();
		bit [3:0] v;
		v = 4'($urandom_range(0, 15));
		if (v < 10) return CH_0 + v;
		return ($urandom_range(0, 1) ? CH_UA : CH_LA) + v - 8'd10;
	endfunction

	function automatic bit [W_CHAR-1:0] junk_char();
		bit [W_CHAR-1:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_NEWLINE || tracker.blank(c) || tracker.nibble_of(c) <= 15);
		return c;
	endfunction

	function automatic bit [W_CHAR-1:0] blank_char();
		case ($urandom_range(0, 4))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_VTAB;
			3: return CH_FFEED;
			default: return CH_CRET;
		endcase
	endfunction

	task automatic send_line(input int digits, input int bad_at);
		for (int i = 0; i <= digits; i++) begin
			if (i == bad_at) offer(1'b0, junk_char(), 6'($urandom));
			if ($urandom_range(0, 7) == 0) offer(1'b0, blank_char(), 6'($urandom));
			if (i < digits) offer(1'b0, digit_char(), 6'($urandom));
		end
		offer(1'b0, CH_NEWLINE, 6'($urandom));
	endtask

	task automatic random_record();
		int unsigned span;
		int unsigned pick;
		int unsigned reads;
		int digits;
		int bad_at;
		span = (width_now == 0) ? 1 : ((width_now > WIDTH_CAP) ? WIDTH_CAP : width_now);
		pick = $urandom_range(0, 99);
		bad_at = -1;
		if (pick < 15) begin
			reads = $urandom_range(1, 3);
			repeat (reads) offer(1'b1, 8'($urandom), 6'($urandom));
			return;
		end
		if (pick < 72) begin
			digits = 2 * $urandom_range(0, span);
		end else if (pick < 80) begin
			digits = 2 * $urandom_range(0, span - 1) + 1;
		end else if (pick < 88) begin
			digits = $urandom_range(2 * span + 1, 20);
		end else begin
			digits = 2 * $urandom_range(0, span);
			bad_at = $urandom_range(0, digits);
		end
		send_line(digits, bad_at);
	endtask

	task automatic directed();
		offer(1'b1, 8'hFF, 6'd0);
		offer(1'b0, CH_NEWLINE, 6'd0);
		offer(1'b0, CH_UF, 6'd0);
		offer(1'b0, CH_SPACE, 6'd0);
		offer(1'b0, CH_LA, 6'd0);
		offer(1'b0, CH_TAB, 6'd0);
		offer(1'b0, CH_VTAB, 6'd0);
		offer(1'b0, CH_FFEED, 6'd0);
		offer(1'b0, CH_CRET, 6'd0);
		offer(1'b0, CH_NEWLINE, 6'd63);
		offer(1'b0, CH_9, 6'd0);
		offer(1'b0, CH_NEWLINE, 6'd0);
		offer(1'b0, 8'hFF, 6'd0);
		offer(1'b0, CH_NEWLINE, 6'd0);
		offer(1'b0, 8'h80, 6'd0);
		offer(1'b0, CH_NEWLINE, 6'd0);
		offer(1'b1, CH_NEWLINE, 6'd63);
		offer(1'b1, 8'h00, 6'd56);
		offer(1'b1, CH_UF, 6'd60);
	endtask

	initial begin
		int unsigned phase_goal;
		bit [W_REC-1:0] widths [PHASES];
		tracker = new();
		calm = 1'b0;
		hold_pending = 1'b0;
		sender_jitter = 1'b1;
		sent_items = 0;
		width_now = REC_BYTES_RESET;
		widths = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd0};
		widths[PHASES-1] = 4'($urandom_range(0, 15));
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= REC_BYTES_RESET;
		stream_if.valid <= 1'b0;
		stream_if.mode <= '0;
		stream_if.char_byte <= '0;
		stream_if.bit_index <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) write_width(widths[p]);
			if (p == 2) hold_pending = 1'b1;
			if (p == PHASES - 1) calm = 1'b1;
			phase_goal = sent_items + RANDOM_ITEMS / PHASES;
			while (sent_items < phase_goal) random_record();
		end
		settle();
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		int unsigned stall_left;
		bit sink_jitter;
		stall_left = 0;
		sink_jitter = 1'b1;
		result_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (result_if.valid === 1'b1 && result_if.ready === 1'b1)
				tracker.match_result(result_if.kind, result_if.bit_count, result_if.line_total);
			@(posedge clk);
			if (!calm && $urandom_range(0, 29) == 0) sink_jitter = !sink_jitter;
			if (hold_pending) begin
				hold_pending = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !calm && sink_jitter && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 15);
			end
			if (stall_left != 0) begin
				stall_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ((stream_if.valid === 1'b1 && stream_if.ready === 1'b1) ||
					(result_if.valid === 1'b1 && result_if.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule
